### rtl/core/fln_pkg.sv
// ----------------------------------------------------------------------------
// fln_pkg
// Shared types, constants and helpers for the single-precision natural log
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fln_pkg;

    // binary32 constants
    localparam logic [31:0] BIAS_BITS   = 32'h3f2aaaab;
    localparam logic [31:0] EXP_MASK    = 32'hff800000;
    localparam logic [31:0] MAX_FINITE  = 32'h7f7fffff;
    localparam logic [31:0] QUIET_BIT   = 32'h00400000;
    localparam logic [31:0] DEFAULT_NAN = 32'h7fc00000;
    localparam logic [31:0] NEG_INF     = 32'hff800000;
    localparam logic [31:0] POS_INF     = 32'h7f800000;
    localparam logic [31:0] LN2_BITS    = 32'h3f317218;
    localparam logic [31:0] MINUS_ONE   = 32'hbf800000;

    // number of horner steps (multiply then add)
    localparam int unsigned HORNER_STEPS = 8;

    // side information that rides along with each arithmetic operation
    typedef struct packed {
        logic [31:0] f;      // reduced argument (or m before reduction)
        logic [31:0] nl;     // n * ln2
        logic        spec;   // special-case result selected
        logic [31:0] sbits;  // special-case result
    } side_t;

    // polynomial coefficients, index 0 is the linear term
    function automatic logic [31:0] coef(input logic [3:0] idx);
        logic [31:0] c;
        case (idx)
            4'd0:    c = 32'h3f800000;
            4'd1:    c = 32'hbeffffe9;
            4'd2:    c = 32'h3eaaaa73;
            4'd3:    c = 32'hbe800a86;
            4'd4:    c = 32'h3e4cec1d;
            4'd5:    c = 32'hbe281126;
            4'd6:    c = 32'h3e0f3bc9;
            4'd7:    c = 32'hbe1dba8f;
            4'd8:    c = 32'h3e0fef44;
            default: c = 32'h00000000;
        endcase
        return c;
    endfunction

    // leading zero count of a 27-bit mantissa field
    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd27;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (v[i] && !found) begin
                n     = 5'(26 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/core/fln_fmul.sv
// ----------------------------------------------------------------------------
// fln_fmul
// Two-stage binary32 multiplier, round to nearest even, side data carried
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fln_fmul
    import fln_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire side_t       in_side,
    output logic             out_valid,
    output logic [31:0]      res,
    output side_t            out_side
);

    logic        v1_reg, v2_reg;
    logic [47:0] prod_reg;
    logic [9:0]  exp1_reg;
    logic        sign1_reg, zero1_reg;
    side_t       side1_reg, side2_reg;
    logic [31:0] res_reg, res_next;

    // stage 1: mantissa product and raw exponent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
            exp1_reg  <= {2'b00, a[30:23]} + {2'b00, b[30:23]} - 10'd127;
            sign1_reg <= a[31] ^ b[31];
            zero1_reg <= (a[30:23] == 8'd0) || (b[30:23] == 8'd0);
            side1_reg <= in_side;
            side2_reg <= side1_reg;
            res_reg   <= res_next;
        end
    end

    // stage 2: normalize by one place and round
    always_comb
    begin
        logic [22:0] mant;
        logic        g, st, up;
        logic [23:0] mr;
        logic [9:0]  e;
        if (prod_reg[47])
        begin
            mant = prod_reg[46:24];
            g    = prod_reg[23];
            st   = |prod_reg[22:0];
            e    = exp1_reg + 10'd1;
        end
        else
        begin
            mant = prod_reg[45:23];
            g    = prod_reg[22];
            st   = |prod_reg[21:0];
            e    = exp1_reg;
        end
        up = g & (st | mant[0]);
        mr = {1'b0, mant} + {23'd0, up};
        if (mr[23])
            e = e + 10'd1;
        if (zero1_reg)
            res_next = {sign1_reg, 31'd0};
        else
            res_next = {sign1_reg, e[7:0], mr[22:0]};
    end

    assign out_valid = v2_reg;
    assign res       = res_reg;
    assign out_side  = side2_reg;

endmodule

`default_nettype wire

### rtl/core/fln_fadd.sv
// ----------------------------------------------------------------------------
// fln_fadd
// Three-stage binary32 adder, round to nearest even, side data carried
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fln_fadd
    import fln_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire side_t       in_side,
    output logic             out_valid,
    output logic [31:0]      res,
    output side_t            out_side
);

    logic        v1_reg, v2_reg, v3_reg;
    side_t       side1_reg, side2_reg, side3_reg;

    // stage 1 registers
    logic [7:0]  e1_reg;
    logic [26:0] ma1_reg, mb1_reg;
    logic        s1_reg, sub1_reg, bz1_reg, zs1_reg;
    // stage 2 registers
    logic [27:0] sum2_reg;
    logic [4:0]  lz2_reg;
    logic [7:0]  e2_reg;
    logic        s2_reg, bz2_reg, zs2_reg;
    // stage 3 register
    logic [31:0] res_reg;

    logic [7:0]  e1_next;
    logic [26:0] ma1_next, mb1_next;
    logic        s1_next, sub1_next, bz1_next, zs1_next;
    logic [27:0] sum2_next;
    logic [31:0] res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side1_reg <= in_side;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
            e1_reg    <= e1_next;
            ma1_reg   <= ma1_next;
            mb1_reg   <= mb1_next;
            s1_reg    <= s1_next;
            sub1_reg  <= sub1_next;
            bz1_reg   <= bz1_next;
            zs1_reg   <= zs1_next;
            sum2_reg  <= sum2_next;
            lz2_reg   <= lzc27(sum2_next[26:0]);
            e2_reg    <= e1_reg;
            s2_reg    <= s1_reg;
            bz2_reg   <= bz1_reg;
            zs2_reg   <= zs1_reg;
            res_reg   <= res_next;
        end
    end

    // stage 1: order by magnitude and align the smaller operand
    always_comb
    begin
        logic [31:0] big, sml;
        logic [7:0]  d;
        logic [4:0]  dc;
        logic [49:0] sh;
        if (a[30:0] >= b[30:0])
        begin
            big = a;
            sml = b;
        end
        else
        begin
            big = b;
            sml = a;
        end
        d  = big[30:23] - sml[30:23];
        dc = (d > 8'd31) ? 5'd31 : d[4:0];
        sh = {1'b1, sml[22:0], 26'd0} >> dc;
        e1_next   = big[30:23];
        ma1_next  = {1'b1, big[22:0], 3'd0};
        mb1_next  = (sml[30:23] == 8'd0) ? 27'd0 : {sh[49:24], |sh[23:0]};
        s1_next   = big[31];
        sub1_next = big[31] ^ sml[31];
        bz1_next  = (big[30:23] == 8'd0);
        zs1_next  = a[31] & b[31];
    end

    // stage 2: add or subtract the aligned mantissas
    assign sum2_next = sub1_reg ? ({1'b0, ma1_reg} - {1'b0, mb1_reg})
                                : ({1'b0, ma1_reg} + {1'b0, mb1_reg});

    // stage 3: normalize and round
    always_comb
    begin
        logic [26:0] nrm;
        logic [9:0]  e;
        logic        up;
        logic [24:0] mr;
        if (sum2_reg[27])
        begin
            nrm = {sum2_reg[27:2], sum2_reg[1] | sum2_reg[0]};
            e   = {2'b00, e2_reg} + 10'd1;
        end
        else
        begin
            nrm = sum2_reg[26:0] << lz2_reg;
            e   = {2'b00, e2_reg} - {5'd0, lz2_reg};
        end
        up = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
        // rounding carry out of the hidden bit
        mr = {1'b0, nrm[26:3]} + {24'd0, up};
        if (mr[24])
            e = e + 10'd1;
        if (bz2_reg)
            res_next = {zs2_reg, 31'd0};
        else if (sum2_reg == 28'd0)
            res_next = 32'd0;
        else
            res_next = {s2_reg, e[7:0], mr[22:0]};
    end

    assign out_valid = v3_reg;
    assign res       = res_reg;
    assign out_side  = side3_reg;

endmodule

`default_nettype wire

### rtl/core/float_natural_log.sv
// ----------------------------------------------------------------------------
// float_natural_log
// When not stalled, pipelined natural logarithm of one binary32 word per cycle
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit first)      transfer
//  s_axis    in   tdata[31:0] = x_bits        tvalid & tready
//  m_axis    out  tdata[31:0] = log_bits      tvalid & tready
//
// one transaction enters per cycle while the output is not stalled; the stages
// are a decode stage, the n*ln2 multiply, the argument reduction add, eight
// horner steps of multiply plus add, the last multiply and the final add.
// reset clears all valid bits; data registers are not reset.
// the whole pipeline holds while the output transaction waits, nothing is
// dropped or repeated; the input is held off for as long as the output waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module float_natural_log
    import fln_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] x_bits
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] log_bits
);

    logic        adv;

    // decode stage registers
    logic        v0_reg;
    logic [31:0] nf_reg, nf_next;
    logic [31:0] m_reg, m_next;
    logic        spec_reg, spec_next;
    logic [31:0] sbits_reg, sbits_next;

    // global advance: move when the output is empty or being taken
    assign adv           = m_axis_tready | ~m_axis_tvalid;
    assign s_axis_tready = adv;

    // special cases, exponent split and conversion of n to float
    always_comb
    begin
        logic [30:0] mag;
        logic [31:0] e;
        logic [8:0]  top;
        logic [8:0]  amag;
        logic [3:0]  p;
        logic [31:0] mant;
        mag = s_axis_tdata[30:0];
        spec_next  = 1'b1;
        sbits_next = POS_INF;
        if (mag > POS_INF[30:0])
            sbits_next = s_axis_tdata | QUIET_BIT;
        else if (mag == 31'd0)
            sbits_next = NEG_INF;
        else if (s_axis_tdata[31])
            sbits_next = DEFAULT_NAN;
        else if (s_axis_tdata > MAX_FINITE)
            sbits_next = POS_INF;
        else
            spec_next = 1'b0;
        e      = (s_axis_tdata - BIAS_BITS) & EXP_MASK;
        top    = e[31:23];
        m_next = s_axis_tdata - e;
        amag   = top[8] ? (9'd0 - top) : top;
        p      = 4'd0;
        for (int i = 0; i < 9; i++)
        begin
            if (amag[i])
                p = 4'(i);
        end
        mant = {23'd0, amag} << (5'd23 - {1'b0, p});
        if (amag == 9'd0)
            nf_next = 32'd0;
        else
            nf_next = {top[8], 8'd127 + {4'd0, p}, mant[22:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv)
            v0_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nf_reg    <= nf_next;
            m_reg     <= m_next;
            spec_reg  <= spec_next;
            sbits_reg <= sbits_next;
        end
    end

    // n * ln2
    logic        nl_v;
    logic [31:0] nl_res;
    side_t       nl_side;

    fln_fmul u_mul_nl (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v0_reg),
        .a         (nf_reg),
        .b         (LN2_BITS),
        .in_side   ('{f: m_reg, nl: 32'd0, spec: spec_reg, sbits: sbits_reg}),
        .out_valid (nl_v),
        .res       (nl_res),
        .out_side  (nl_side)
    );

    // f = m - 1
    logic        f_v;
    logic [31:0] f_res;
    side_t       f_side;

    fln_fadd u_add_f (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (nl_v),
        .a         (nl_side.f),
        .b         (MINUS_ONE),
        .in_side   ('{f: 32'd0, nl: nl_res, spec: nl_side.spec, sbits: nl_side.sbits}),
        .out_valid (f_v),
        .res       (f_res),
        .out_side  (f_side)
    );

    // horner chain
    logic        hv    [HORNER_STEPS+1];
    logic [31:0] hr    [HORNER_STEPS+1];
    side_t       hs    [HORNER_STEPS+1];

    assign hv[0] = f_v;
    assign hr[0] = coef(4'd8);
    assign hs[0] = '{f: f_res, nl: f_side.nl, spec: f_side.spec, sbits: f_side.sbits};

    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_horner
        logic        mv;
        logic [31:0] mr;
        side_t       ms;

        fln_fmul u_mul (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (hv[k]),
            .a         (hr[k]),
            .b         (hs[k].f),
            .in_side   (hs[k]),
            .out_valid (mv),
            .res       (mr),
            .out_side  (ms)
        );

        fln_fadd u_add (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (mv),
            .a         (mr),
            .b         (coef(4'(HORNER_STEPS - 1 - k))),
            .in_side   (ms),
            .out_valid (hv[k+1]),
            .res       (hr[k+1]),
            .out_side  (hs[k+1])
        );
    end

    // last multiply by f
    logic        p_v;
    logic [31:0] p_res;
    side_t       p_side;

    fln_fmul u_mul_last (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (hv[HORNER_STEPS]),
        .a         (hr[HORNER_STEPS]),
        .b         (hs[HORNER_STEPS].f),
        .in_side   (hs[HORNER_STEPS]),
        .out_valid (p_v),
        .res       (p_res),
        .out_side  (p_side)
    );

    // n*ln2 + polynomial
    logic        o_v;
    logic [31:0] o_res;
    side_t       o_side;

    fln_fadd u_add_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p_v),
        .a         (p_side.nl),
        .b         (p_res),
        .in_side   (p_side),
        .out_valid (o_v),
        .res       (o_res),
        .out_side  (o_side)
    );

    // output selection
    assign m_axis_tvalid = o_v;
    assign m_axis_tdata  = o_side.spec ? o_side.sbits : o_res;

endmodule

`default_nettype wire
